@@ rtl/ow_mst_pkg.sv @@
package ow_mst_pkg;

    // Width of one timing register.
    localparam int REG_WIDTH = 10;

    // Number of timing registers and their indexes.
    localparam int NUM_REGS = 7;
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd3;
    localparam logic [2:0] REG_SLOT          = 3'd4;
    localparam logic [2:0] REG_READ_LOW      = 3'd5;
    localparam logic [2:0] REG_READ_WAIT     = 3'd6;

    // Register values after reset, in ticks.
    localparam logic [REG_WIDTH-1:0] DEF_RESET_LOW     = 10'd480;
    localparam logic [REG_WIDTH-1:0] DEF_PRESENCE_WAIT = 10'd80;
    localparam logic [REG_WIDTH-1:0] DEF_RESET_RECOVER = 10'd400;
    localparam logic [REG_WIDTH-1:0] DEF_WRITE_ONE_LOW = 10'd1;
    localparam logic [REG_WIDTH-1:0] DEF_SLOT          = 10'd60;
    localparam logic [REG_WIDTH-1:0] DEF_READ_LOW      = 10'd2;
    localparam logic [REG_WIDTH-1:0] DEF_READ_WAIT     = 10'd60;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Bus phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE        = 9'b000000001,
        PH_RST_LOW     = 9'b000000010,
        PH_RST_WAIT    = 9'b000000100,
        PH_RST_RECOVER = 9'b000001000,
        PH_WR_LOW      = 9'b000010000,
        PH_WR_WAIT     = 9'b000100000,
        PH_RD_LOW      = 9'b001000000,
        PH_RD_SAMPLE   = 9'b010000000,
        PH_RD_WAIT     = 9'b100000000
    } phase_t;

endpackage

@@ rtl/one_wire_bus_master_top.sv @@
// 1-Wire bus master with reset/presence detect, byte write and byte read, bits sent
// least significant first. Each input beat is either a one-microsecond tick with the
// sampled bus level (operation 0) or a command (1 reset, 2 write byte, 3 read byte);
// commands are ignored while busy. Every input beat yields exactly one result beat
// with the drive-low level, busy, a done pulse, the presence flag and the last byte
// read. One beat is taken per clock cycle: the state update is a single combinational
// pass into the state and result registers, and the result register accepts a new
// beat in the same cycle in which the previous one is taken, so the rate is one beat
// per cycle whenever the result side is ready. The result beat appears in the cycle
// after the input beat is accepted. Timing registers are counted in ticks and are
// clamped to what a COUNT_WIDTH-bit counter can hold.
module one_wire_bus_master_top
    import ow_mst_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [9:2] write_byte, [10] line_level, [15:11] zero
    input  logic [15:0] s_tdata,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_seen,
    // [11:4] read_value, [15:12] zero
    output logic [15:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = COUNT_WIDTH;
    localparam int DW = (CW > REG_WIDTH) ? CW : REG_WIDTH;
    localparam logic [DW-1:0] CNT_MAX_W = DW'((1 << COUNT_WIDTH) - 1);
    localparam logic [CW-1:0] CNT_MAX = '1;

    // Clamp a register value to the counter range; zero acts as one unless allowed.
    function automatic logic [CW-1:0] clamp_dur(input logic [REG_WIDTH-1:0] v,
                                                 input logic allow_zero);
        logic [DW-1:0] w;
        w = DW'(v);
        if (w == '0 && !allow_zero) begin
            w = DW'(1);
        end
        if (w > CNT_MAX_W) begin
            w = CNT_MAX_W;
        end
        return w[CW-1:0];
    endfunction

    // Timing registers.
    logic [REG_WIDTH-1:0] rst_low_reg, pres_wait_reg, rst_rec_reg;
    logic [REG_WIDTH-1:0] wr1_low_reg, slot_reg, rd_low_reg, rd_wait_reg;

    // Bus state.
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    logic          pres_reg, pres_next;
    logic [7:0]    rdval_reg, rdval_next;
    logic          done;

    // Result register.
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_data_reg, m_data_next;

    // Decoded input beat.
    op_t           in_op;
    logic [7:0]    in_byte;
    logic          in_line;
    logic          in_accept;

    // Clamped durations and the incremented count.
    logic [CW-1:0] d_rst_low, d_pres_wait, d_rst_rec, d_wr1_low, d_slot;
    logic [CW-1:0] d_rd_low, d_rd_wait, d_wr_low, cnt_inc;
    logic          cur_bit;
    logic          cfg_write;

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_byte  = s_tdata[9:2];
    assign in_line  = s_tdata[10];
    assign s_tready = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign d_rst_low   = clamp_dur(rst_low_reg, 1'b0);
    assign d_pres_wait = clamp_dur(pres_wait_reg, 1'b0);
    assign d_rst_rec   = clamp_dur(rst_rec_reg, 1'b1);
    assign d_wr1_low   = clamp_dur(wr1_low_reg, 1'b0);
    assign d_slot      = clamp_dur(slot_reg, 1'b0);
    assign d_rd_low    = clamp_dur(rd_low_reg, 1'b0);
    assign d_rd_wait   = clamp_dur(rd_wait_reg, 1'b1);
    assign cur_bit     = shift_reg[bit_reg];
    assign d_wr_low    = cur_bit ? d_wr1_low : d_slot;
    assign cnt_inc     = (cnt_reg < CNT_MAX) ? cnt_reg + CW'(1) : cnt_reg;

    // Configuration writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rst_low_reg   <= DEF_RESET_LOW;
            pres_wait_reg <= DEF_PRESENCE_WAIT;
            rst_rec_reg   <= DEF_RESET_RECOVER;
            wr1_low_reg   <= DEF_WRITE_ONE_LOW;
            slot_reg      <= DEF_SLOT;
            rd_low_reg    <= DEF_READ_LOW;
            rd_wait_reg   <= DEF_READ_WAIT;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_RESET_LOW:     rst_low_reg   <= pwdata[REG_WIDTH-1:0];
                REG_PRESENCE_WAIT: pres_wait_reg <= pwdata[REG_WIDTH-1:0];
                REG_RESET_RECOVER: rst_rec_reg   <= pwdata[REG_WIDTH-1:0];
                REG_WRITE_ONE_LOW: wr1_low_reg   <= pwdata[REG_WIDTH-1:0];
                REG_SLOT:          slot_reg      <= pwdata[REG_WIDTH-1:0];
                REG_READ_LOW:      rd_low_reg    <= pwdata[REG_WIDTH-1:0];
                REG_READ_WAIT:     rd_wait_reg   <= pwdata[REG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_RESET_LOW:     prdata = 32'(rst_low_reg);
            REG_PRESENCE_WAIT: prdata = 32'(pres_wait_reg);
            REG_RESET_RECOVER: prdata = 32'(rst_rec_reg);
            REG_WRITE_ONE_LOW: prdata = 32'(wr1_low_reg);
            REG_SLOT:          prdata = 32'(slot_reg);
            REG_READ_LOW:      prdata = 32'(rd_low_reg);
            REG_READ_WAIT:     prdata = 32'(rd_wait_reg);
            default:           prdata = '0;
        endcase
    end

    // One state update per accepted beat.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        rdval_next = rdval_reg;
        done       = 1'b0;

        if (in_accept) begin
            if (in_op == OP_TICK) begin
                case (phase_reg)
                    PH_IDLE: ;
                    PH_RST_LOW: begin
                        if (cnt_inc >= d_rst_low) begin
                            cnt_next   = '0;
                            phase_next = PH_RST_WAIT;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (cnt_inc >= d_pres_wait) begin
                            cnt_next  = '0;
                            pres_next = !in_line;
                            if (d_rst_rec == '0) begin
                                phase_next = PH_IDLE;
                                bit_next   = '0;
                                done       = 1'b1;
                            end else begin
                                phase_next = PH_RST_RECOVER;
                            end
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    PH_RST_RECOVER: begin
                        if (cnt_inc >= d_rst_rec) begin
                            cnt_next   = '0;
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done       = 1'b1;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    PH_WR_LOW: begin
                        if (cnt_inc >= d_wr_low) begin
                            cnt_next = '0;
                            if (cur_bit) begin
                                phase_next = PH_WR_WAIT;
                            end else if (bit_reg == 3'd7) begin
                                phase_next = PH_IDLE;
                                bit_next   = '0;
                                done       = 1'b1;
                            end else begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_WR_LOW;
                            end
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    PH_WR_WAIT: begin
                        if (cnt_inc >= d_slot) begin
                            cnt_next = '0;
                            if (bit_reg == 3'd7) begin
                                phase_next = PH_IDLE;
                                bit_next   = '0;
                                done       = 1'b1;
                            end else begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_WR_LOW;
                            end
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    PH_RD_LOW: begin
                        if (cnt_inc >= d_rd_low) begin
                            cnt_next   = '0;
                            phase_next = PH_RD_SAMPLE;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    PH_RD_SAMPLE: begin
                        cnt_next = '0;
                        shift_next[bit_reg] = shift_reg[bit_reg] | in_line;
                        if (d_rd_wait != '0) begin
                            phase_next = PH_RD_WAIT;
                        end else if (bit_reg == 3'd7) begin
                            rdval_next = shift_next;
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done       = 1'b1;
                        end else begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_RD_LOW;
                        end
                    end
                    PH_RD_WAIT: begin
                        if (cnt_inc >= d_rd_wait) begin
                            cnt_next = '0;
                            if (bit_reg == 3'd7) begin
                                rdval_next = shift_reg;
                                phase_next = PH_IDLE;
                                bit_next   = '0;
                                done       = 1'b1;
                            end else begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_RD_LOW;
                            end
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                endcase
            end else if (phase_reg == PH_IDLE) begin
                // A command starts its first phase; it does not count as a tick.
                cnt_next = '0;
                bit_next = '0;
                case (in_op)
                    OP_RESET: phase_next = PH_RST_LOW;
                    OP_WRITE: begin
                        shift_next = in_byte;
                        phase_next = PH_WR_LOW;
                    end
                    default: begin
                        shift_next = '0;
                        phase_next = PH_RD_LOW;
                    end
                endcase
            end
        end
    end

    // Result beat built from the updated state.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (in_accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, rdval_next, pres_next, done,
                            (phase_next != PH_IDLE),
                            (phase_next == PH_RST_LOW || phase_next == PH_WR_LOW ||
                             phase_next == PH_RD_LOW)};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            pres_reg    <= 1'b0;
            rdval_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            pres_reg    <= pres_next;
            rdval_reg   <= rdval_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
